// ===== design/hfd_pkg.sv =====
package hfd_pkg;

	// crc-8 parameters, msb first, no reflection, no final xor
	localparam logic [7:0] CRC_INIT = 8'hFF;
	localparam logic [7:0] CRC_POLY = 8'h31;

	// byte positions inside the six-byte frame
	localparam logic [2:0] POS_T_HI  = 3'd0;
	localparam logic [2:0] POS_T_LO  = 3'd1;
	localparam logic [2:0] POS_T_CRC = 3'd2;
	localparam logic [2:0] POS_H_HI  = 3'd3;
	localparam logic [2:0] POS_H_LO  = 3'd4;
	localparam logic [2:0] POS_H_CRC = 3'd5;

	// conversion constants
	localparam logic [16:0] RAW_FULL   = 17'd65535;
	localparam logic [14:0] T_SCALE    = 15'd17500;
	localparam logic [13:0] H_SCALE    = 14'd12500;
	localparam logic [15:0] T_OFFS     = 16'd4500;
	localparam logic [13:0] H_OFFS     = 14'd600;
	localparam logic [13:0] H_MAX      = 14'd10000;
	// offsets scaled by full-scale raw value
	localparam logic [30:0] T_OFFS_RAW = 31'd294907500;
	localparam logic [29:0] H_OFFS_RAW = 30'd39321000;

	// one complete frame handed to the conversion pipeline
	typedef struct packed {
		logic        fail;
		logic [15:0] temp_raw;
		logic [15:0] humid_raw;
	} meas_t;

	// crc-8 update over one byte
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// ===== design/hfd_conv.sv =====
module hfd_conv import hfd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  meas_t              in_meas,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               status,
	output logic signed [14:0] temp_centi_c,
	output logic [13:0]        humid_centi_pct
);

	logic        v_s2;
	logic        fail_s2;
	logic [30:0] pt_s2;
	logic [29:0] ph_s2;
	logic        en2;
	logic        en3;

	// temperature division by 65535: estimate, then one correction step
	logic [14:0] qt0;
	logic [16:0] rt0;
	logic        t_up;
	logic [14:0] qt;
	logic [16:0] rt;
	logic        t_adj;
	logic [15:0] t_val;

	// humidity division and clamp
	logic [13:0] qh0;
	logic [16:0] rh0;
	logic        h_up;
	logic [13:0] qh;
	logic [13:0] h_sub;
	logic [13:0] h_val;

	// stage enables
	assign en3      = !out_valid || !out_stall;
	assign en2      = !v_s2 || en3;
	assign in_stall = !en2;

	// stage 2: scale products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en2) begin
			v_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en2 && in_valid) begin
			fail_s2 <= in_meas.fail;
			pt_s2   <= 31'(in_meas.temp_raw) * 31'(T_SCALE);
			ph_s2   <= 30'(in_meas.humid_raw) * 30'(H_SCALE);
		end
	end

	// temperature: truncate toward zero, so round up when below the offset
	always_comb begin
		qt0   = pt_s2[30:16];
		rt0   = {1'b0, pt_s2[15:0]} + 17'(qt0);
		t_up  = rt0 >= RAW_FULL;
		qt    = qt0 + 15'(t_up);
		rt    = t_up ? rt0 - RAW_FULL : rt0;
		t_adj = (pt_s2 < T_OFFS_RAW) && (rt != 17'd0);
		t_val = 16'(qt) - T_OFFS + 16'(t_adj);
	end

	// humidity: negative values clamp to zero, large ones to full scale
	always_comb begin
		qh0   = ph_s2[29:16];
		rh0   = {1'b0, ph_s2[15:0]} + 17'(qh0);
		h_up  = rh0 >= RAW_FULL;
		qh    = qh0 + 14'(h_up);
		h_sub = qh - H_OFFS;
		if (ph_s2 < H_OFFS_RAW) begin
			h_val = 14'd0;
		end else if (h_sub > H_MAX) begin
			h_val = H_MAX;
		end else begin
			h_val = h_sub;
		end
	end

	// stage 3: result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en3) begin
			out_valid <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en3 && v_s2) begin
			status          <= fail_s2;
			temp_centi_c    <= fail_s2 ? 15'sd0 : $signed(t_val[14:0]);
			humid_centi_pct <= fail_s2 ? 14'd0 : h_val;
		end
	end

endmodule

// ===== design/humidity_temp_frame_decoder_top.sv =====
// Decodes the six-byte sensor frame (temperature word, crc, humidity word, crc)
// and gives one result beat per frame with the crc status and the two values
// in hundredths. One byte beat is taken every cycle while in_stall is low;
// the crc-8 of a byte is worked in the cycle that accepts it. The edge that
// accepts the last byte of a frame loads the frame register; from there the
// frame passes the stage for the two scale multiplications and then the
// result register with the division by the full-scale value and the clamp.
// A result waiting on out_stall does not hold up byte beats until all three
// stages are full. frame_start restarts the byte count and drops a partial
// frame; frames may also follow one another without it.
module humidity_temp_frame_decoder_top import hfd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         frame_byte,
	input  logic               frame_start,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               status,
	output logic signed [14:0] temp_centi_c,
	output logic [13:0]        humid_centi_pct
);

	logic [2:0]  count_q;
	logic [7:0]  crc_q;
	logic [15:0] temp_q;
	logic [15:0] humid_q;
	logic        fail_q;

	logic        restart;
	logic [2:0]  pos;
	logic [7:0]  crc_eff;
	logic        fail_eff;
	logic        accept;

	logic [2:0]  count_d;
	logic [7:0]  crc_d;
	logic [15:0] temp_d;
	logic [15:0] humid_d;
	logic        fail_d;
	logic        frame_done;
	logic        frame_fail;

	logic        v_s1;
	meas_t       meas_s1;
	logic        conv_stall;

	// frame register blocks byte beats only when full and the pipeline stalls
	assign in_stall = v_s1 && conv_stall;
	assign accept   = in_valid && !in_stall;

	// resynchronize on frame start or an unused count value
	assign restart  = frame_start || (count_q > POS_H_CRC);
	assign pos      = restart ? POS_T_HI : count_q;
	assign crc_eff  = restart ? CRC_INIT : crc_q;
	assign fail_eff = restart ? 1'b0 : fail_q;

	// byte position decode and crc update
	always_comb begin
		count_d    = pos + 3'd1;
		crc_d      = crc_eff;
		temp_d     = temp_q;
		humid_d    = humid_q;
		fail_d     = fail_eff;
		frame_done = 1'b0;
		frame_fail = fail_eff || (crc_eff != frame_byte);
		case (pos)
			POS_T_HI: begin
				temp_d = {frame_byte, temp_q[7:0]};
				crc_d  = crc8_byte(crc_eff, frame_byte);
			end
			POS_T_LO: begin
				temp_d = {temp_q[15:8], frame_byte};
				crc_d  = crc8_byte(crc_eff, frame_byte);
			end
			POS_T_CRC: begin
				fail_d = frame_fail;
				crc_d  = CRC_INIT;
			end
			POS_H_HI: begin
				humid_d = {frame_byte, humid_q[7:0]};
				crc_d   = crc8_byte(crc_eff, frame_byte);
			end
			POS_H_LO: begin
				humid_d = {humid_q[15:8], frame_byte};
				crc_d   = crc8_byte(crc_eff, frame_byte);
			end
			POS_H_CRC: begin
				frame_done = 1'b1;
				count_d    = POS_T_HI;
				crc_d      = CRC_INIT;
				fail_d     = 1'b0;
			end
			default: begin
				count_d = POS_T_HI;
			end
		endcase
	end

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= POS_T_HI;
			crc_q   <= CRC_INIT;
			temp_q  <= 16'd0;
			humid_q <= 16'd0;
			fail_q  <= 1'b0;
		end else if (accept) begin
			count_q <= count_d;
			crc_q   <= crc_d;
			temp_q  <= temp_d;
			humid_q <= humid_d;
			fail_q  <= fail_d;
		end
	end

	// stage 1: completed frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept && frame_done) begin
			v_s1 <= 1'b1;
		end else if (!conv_stall) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && frame_done) begin
			meas_s1.fail      <= frame_fail;
			meas_s1.temp_raw  <= temp_q;
			meas_s1.humid_raw <= humid_q;
		end
	end

	hfd_conv u_conv (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (v_s1),
		.in_stall        (conv_stall),
		.in_meas         (meas_s1),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.status          (status),
		.temp_centi_c    (temp_centi_c),
		.humid_centi_pct (humid_centi_pct)
	);

	// a failed frame reports zero values
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> temp_centi_c == 15'sd0 && humid_centi_pct == 14'd0)
		else $error("failed frame with nonzero values");

	// humidity stays clamped
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> humid_centi_pct <= H_MAX)
		else $error("humidity above clamp");

	// temperature within the conversion range
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> temp_centi_c >= -15'sd4500 && temp_centi_c <= 15'sd13000)
		else $error("temperature out of range");

	// byte count never reaches an unused value
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= POS_H_CRC)
		else $error("byte count out of range");

endmodule
